FILE: rtl/core/ehc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ehc_pkg;

   // One request as it sits in the input register
   typedef struct packed {
      logic [7:0] head_byte;
      logic       no_byte;
      logic       last_byte;
   } item_type;

   // One classification result
   typedef struct packed {
      logic [1:0] format_kind;
      logic [2:0] status;
      logic [1:0] elf_type;
      logic [7:0] interp_start;
      logic [7:0] interp_length;
      logic       has_argument;
      logic [7:0] arg_start;
      logic [7:0] arg_length;
   } result_type;

   // Format kinds
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_ELF     = 2'd1;
   localparam logic [1:0] KIND_SCRIPT  = 2'd2;
   localparam logic [1:0] KIND_HOST_MZ = 2'd3;

   // Status codes
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_ELF   = 3'd1;
   localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
   localparam logic [2:0] STAT_NO_INTERP = 3'd3;
   localparam logic [2:0] STAT_TOO_LONG  = 3'd4;

   // ELF constants
   localparam logic [7:0]  ELF_MAG0      = 8'h7F;
   localparam logic [7:0]  ELF_MAG1      = 8'h45;  // 'E'
   localparam logic [7:0]  ELF_MAG2      = 8'h4C;  // 'L'
   localparam logic [7:0]  ELF_MAG3      = 8'h46;  // 'F'
   localparam logic [7:0]  ELF_CLASS64   = 8'h02;
   localparam logic [7:0]  ELF_DATA_LSB  = 8'h01;
   localparam logic [15:0] ELF_TYPE_EXEC = 16'd2;
   localparam logic [15:0] ELF_TYPE_DYN  = 16'd3;
   localparam logic [15:0] MACHINE_RESET = 16'd62;

   // Byte offsets inside the ELF header
   localparam int POS_MAG1      = 1;
   localparam int POS_MAG2      = 2;
   localparam int POS_MAG3      = 3;
   localparam int POS_CLASS     = 4;
   localparam int POS_DATA      = 5;
   localparam int POS_TYPE_LO   = 16;
   localparam int POS_TYPE_HI   = 17;
   localparam int POS_MACH_LO   = 18;
   localparam int POS_MACH_HI   = 19;
   localparam int ELF_HEAD_MIN  = 20;
   localparam int SCRIPT_START  = 2;

   // Characters
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

endpackage

`default_nettype wire

FILE: rtl/core/ehc_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ehc_scan #(
   parameter int HEAD_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  ehc_pkg::item_type   item,
   input  logic [15:0]         expected_machine,
   output ehc_pkg::result_type result
);
   import ehc_pkg::*;

   localparam int CW = $clog2(HEAD_BYTES + 1);
   localparam logic [CW-1:0] HEAD_LIMIT = CW'(HEAD_BYTES);

   // Script line scan phases
   localparam logic [1:0] PH_BEFORE = 2'd0;
   localparam logic [1:0] PH_NAME   = 2'd1;
   localparam logic [1:0] PH_BLANKS = 2'd2;
   localparam logic [1:0] PH_ARG    = 2'd3;

   // Offsets are reported modulo 256
   function automatic logic [7:0] low8(input logic [CW-1:0] v);
      logic [CW+7:0] w;
      w = {8'd0, v};
      return w[7:0];
   endfunction

   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    flags_ff, flags_in;        // bit0 ELF, bit1 #!, bit2 MZ
   logic          ident_ff, ident_in;
   logic [15:0]   type_ff, type_in;
   logic [15:0]   machine_ff, machine_in;
   logic          ended_ff, ended_in;
   logic [CW-1:0] name_begin_ff, name_begin_in;
   logic [CW-1:0] name_finish_ff, name_finish_in;
   logic [CW-1:0] arg_begin_ff, arg_begin_in;
   logic [CW-1:0] nonblank_ff, nonblank_in;
   logic [1:0]    phase_ff, phase_in;

   logic          take;
   logic [7:0]    b;
   logic          blank;
   logic [CW-1:0] ilen_w;
   logic [CW-1:0] alen_w;

   assign b     = item.head_byte;
   assign take  = !item.no_byte && (count_ff < HEAD_LIMIT);
   assign blank = (b == CH_SPACE) || (b == CH_TAB);

   // Per-byte state update
   always_comb begin
      count_in       = count_ff;
      flags_in       = flags_ff;
      ident_in       = ident_ff;
      type_in        = type_ff;
      machine_in     = machine_ff;
      ended_in       = ended_ff;
      name_begin_in  = name_begin_ff;
      name_finish_in = name_finish_ff;
      arg_begin_in   = arg_begin_ff;
      nonblank_in    = nonblank_ff;
      phase_in       = phase_ff;
      if (take) begin
         count_in = count_ff + CW'(1);
         // magic and header field capture
         unique case (count_ff)
            CW'(0): begin
               flags_in = {b == CH_M, b == CH_HASH, b == ELF_MAG0};
            end
            CW'(POS_MAG1): begin
               flags_in = flags_ff & {b == CH_Z, b == CH_BANG, b == ELF_MAG1};
            end
            CW'(POS_MAG2): flags_in[0] = flags_ff[0] && (b == ELF_MAG2);
            CW'(POS_MAG3): flags_in[0] = flags_ff[0] && (b == ELF_MAG3);
            CW'(POS_CLASS): ident_in = (b == ELF_CLASS64);
            CW'(POS_DATA): ident_in = ident_ff && (b == ELF_DATA_LSB);
            CW'(POS_TYPE_LO): type_in[7:0] = b;
            CW'(POS_TYPE_HI): type_in[15:8] = b;
            CW'(POS_MACH_LO): machine_in[7:0] = b;
            CW'(POS_MACH_HI): machine_in[15:8] = b;
            default: ;
         endcase
         // interpreter line scan
         if (count_ff >= CW'(SCRIPT_START) && !ended_ff) begin
            if (b == CH_NUL || b == CH_LF) begin
               ended_in = 1'b1;
            end else if (blank) begin
               if (phase_ff == PH_NAME) begin
                  name_finish_in = count_ff;
                  phase_in       = PH_BLANKS;
               end
            end else begin
               nonblank_in = count_ff;
               if (phase_ff == PH_BEFORE) begin
                  name_begin_in = count_ff;
                  phase_in      = PH_NAME;
               end else if (phase_ff == PH_BLANKS) begin
                  arg_begin_in = count_ff;
                  phase_in     = PH_ARG;
               end
            end
         end
      end
   end

   // Classification from the updated state
   assign ilen_w = (phase_in == PH_NAME) ? (nonblank_in + CW'(1) - name_begin_in)
                                         : (name_finish_in - name_begin_in);
   assign alen_w = nonblank_in + CW'(1) - arg_begin_in;

   always_comb begin
      result = '0;
      if (count_in >= CW'(4) && flags_in[0]) begin
         if (count_in < CW'(ELF_HEAD_MIN) || !ident_in ||
             machine_in != expected_machine) begin
            result.status = STAT_BAD_ELF;
         end else if (type_in != ELF_TYPE_EXEC && type_in != ELF_TYPE_DYN) begin
            result.status = STAT_BAD_TYPE;
         end else begin
            result.format_kind = KIND_ELF;
            result.elf_type    = type_in[1:0];
         end
      end else if (count_in >= CW'(2) && flags_in[1]) begin
         if (!ended_in && count_in >= HEAD_LIMIT) begin
            result.status = STAT_TOO_LONG;
         end else if (phase_in == PH_BEFORE) begin
            result.status = STAT_NO_INTERP;
         end else begin
            result.format_kind   = KIND_SCRIPT;
            result.interp_start  = low8(name_begin_in);
            result.interp_length = low8(ilen_w);
            if (phase_in == PH_ARG) begin
               result.has_argument = 1'b1;
               result.arg_start    = low8(arg_begin_in);
               result.arg_length   = low8(alen_w);
            end
         end
      end else if (count_in >= CW'(2) && flags_in[2]) begin
         result.format_kind = KIND_HOST_MZ;
      end
   end

   // Scan state; a last request clears it for the next head
   always_ff @(posedge clock) begin
      if (reset || (step_en && item.last_byte)) begin
         count_ff       <= '0;
         flags_ff       <= '0;
         ident_ff       <= 1'b0;
         type_ff        <= '0;
         machine_ff     <= '0;
         ended_ff       <= 1'b0;
         name_begin_ff  <= '0;
         name_finish_ff <= '0;
         arg_begin_ff   <= '0;
         nonblank_ff    <= '0;
         phase_ff       <= PH_BEFORE;
      end else if (step_en) begin
         count_ff       <= count_in;
         flags_ff       <= flags_in;
         ident_ff       <= ident_in;
         type_ff        <= type_in;
         machine_ff     <= machine_in;
         ended_ff       <= ended_in;
         name_begin_ff  <= name_begin_in;
         name_finish_ff <= name_finish_in;
         arg_begin_ff   <= arg_begin_in;
         nonblank_ff    <= nonblank_in;
         phase_ff       <= phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/executable_head_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    head_byte, no_byte, last_byte
// rsp      out        rsp_valid/stall    format_kind .. arg_length
// csr      in         csr_valid/ready    expected_machine (16 bits)
//
// One request per cycle, sustained, while no last request waits on a stalled
// result. A request is loaded into the input register, then its byte is
// scanned and, on a last request, the result is loaded into the output
// register. Reset is synchronous; it clears both valid bits, the scan state,
// and sets expected_machine to 62. A stalled result holds only a last request
// behind it, and the requests after that wait; other requests keep flowing.

module executable_head_classifier_unit #(
   parameter int HEAD_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_head_byte,
   input  logic        req_no_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_format_kind,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_elf_type,
   output logic [7:0]  rsp_interp_start,
   output logic [7:0]  rsp_interp_length,
   output logic        rsp_has_argument,
   output logic [7:0]  rsp_arg_start,
   output logic [7:0]  rsp_arg_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_machine
);
   import ehc_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic [15:0] machine_ff;

   logic       req_accept;
   logic       out_free;
   logic       s1_go;
   logic       s1_emit;
   result_type scan_result;

   // Flow control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_go      = s1_valid_ff && (!s1_item_ff.last_byte || out_free);
   assign s1_emit    = s1_go && s1_item_ff.last_byte;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_emit || (rsp_valid_ff && rsp_stall);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_item_ff <= '{head_byte: req_head_byte, no_byte: req_no_byte,
                         last_byte: req_last_byte};
      end
   end

   // Machine register
   always_ff @(posedge clock) begin
      if (reset) begin
         machine_ff <= MACHINE_RESET;
      end else if (csr_valid && csr_ready) begin
         machine_ff <= csr_expected_machine;
      end
   end

   ehc_scan #(
      .HEAD_BYTES(HEAD_BYTES)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .step_en         (s1_go),
      .item            (s1_item_ff),
      .expected_machine(machine_ff),
      .result          (scan_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_emit) begin
         rsp_data_ff <= scan_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_format_kind   = rsp_data_ff.format_kind;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_elf_type      = rsp_data_ff.elf_type;
   assign rsp_interp_start  = rsp_data_ff.interp_start;
   assign rsp_interp_length = rsp_data_ff.interp_length;
   assign rsp_has_argument  = rsp_data_ff.has_argument;
   assign rsp_arg_start     = rsp_data_ff.arg_start;
   assign rsp_arg_length    = rsp_data_ff.arg_length;

endmodule

`default_nettype wire
